[rtl/fpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg: frustum point containment shared definitions
// Register file geometry, default field widths and the pipeline advance bundle.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int NUM_PLANES         = 6;
	localparam int CFG_WIDTH          = 64;
	localparam int CFG_IDX_WIDTH      = 3;
	localparam int COORD_WIDTH_DEF    = 16;
	localparam int NORMAL_WIDTH_DEF   = 11;

	// per-stage load enables, driven by the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} fpc_adv_t;

endpackage

[rtl/fpc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_if: point and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface fpc_point_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] px;
	logic signed [COORD_WIDTH-1:0] py;
	logic signed [COORD_WIDTH-1:0] pz;

	modport source (output valid, output px, output py, output pz, input ready);
	modport sink   (input valid, input px, input py, input pz, output ready);
endinterface

interface fpc_result_if;
	logic       valid;
	logic       ready;
	logic       inside_res;
	logic [5:0] failed_planes;

	modport source (output valid, output inside_res, output failed_planes, input ready);
	modport sink   (input valid, input inside_res, input failed_planes, output ready);
endinterface

[rtl/fpc_plane_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_plane_regs: plane register file
// Six packed plane words, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module fpc_plane_regs
	import fpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_idx,
	input  logic [CFG_WIDTH-1:0]     cfg_data,
	output logic [CFG_WIDTH-1:0]     plane [NUM_PLANES]
);

	logic [CFG_WIDTH-1:0] plane_q [NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we && (int'(cfg_idx) < NUM_PLANES)) begin
			plane_q[cfg_idx] <= cfg_data;
		end
	end

	assign plane = plane_q;

endmodule

[rtl/fpc_plane_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_plane_eval: one plane side test
// Three stages: products, partial sums, signed distance sign check.
// ----------------------------------------------------------------------------
module fpc_plane_eval
	import fpc_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
	input  logic                          clk,
	input  fpc_adv_t                      adv,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	input  logic [CFG_WIDTH-1:0]          plane,
	output logic                          fail_s3
);

	localparam int PROD_W = COORD_WIDTH + NORMAL_WIDTH;
	localparam int OFF_W  = CFG_WIDTH - 3 * NORMAL_WIDTH;
	localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 3;

	logic signed [NORMAL_WIDTH-1:0] nx, ny, nz;
	logic signed [OFF_W-1:0]        d;

	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [SUM_W-1:0]  sum_xy_s2, sum_zd_s2;
	logic signed [SUM_W-1:0]  margin;

	assign nx = $signed(plane[NORMAL_WIDTH-1:0]);
	assign ny = $signed(plane[2*NORMAL_WIDTH-1:NORMAL_WIDTH]);
	assign nz = $signed(plane[3*NORMAL_WIDTH-1:2*NORMAL_WIDTH]);
	assign d  = $signed(plane[CFG_WIDTH-1:3*NORMAL_WIDTH]);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_x_s1 <= PROD_W'(px * nx);
			prod_y_s1 <= PROD_W'(py * ny);
			prod_z_s1 <= PROD_W'(pz * nz);
		end
		if (adv.s2) begin
			sum_xy_s2 <= SUM_W'(prod_x_s1) + SUM_W'(prod_y_s1);
			sum_zd_s2 <= SUM_W'(prod_z_s1) - SUM_W'(d);
		end
		if (adv.s3) begin
			fail_s3 <= margin[SUM_W-1] || (margin == '0);
		end
	end

	assign margin = sum_xy_s2 + sum_zd_s2;

endmodule

[rtl/frustum_point_containment.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_point_containment: view frustum point culling test
// Tests a point against six configured planes, reports inside and failed mask.
// ----------------------------------------------------------------------------
// One point per clock unless res.ready stalls the pipeline: the input transfer
// loads the products, then follow two partial sums, distance sign, and the
// output register, which presents the result on the output channel. All six
// planes are evaluated in
// parallel lanes. Each plane word packs nx, ny, nz (signed Q1.9 by default)
// from bit 0 upward and a signed offset in the remaining upper bits; a plane
// fails when n.p - d <= 0, and the point is inside when no plane fails.
// Plane registers reset to zero and must only be written while idle.
// ----------------------------------------------------------------------------
module frustum_point_containment
	import fpc_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_idx,
	input  logic [CFG_WIDTH-1:0]     cfg_data,
	fpc_point_if.sink                pt,
	fpc_result_if.source             res
);

	logic [CFG_WIDTH-1:0]  plane [NUM_PLANES];
	logic [NUM_PLANES-1:0] fail_s3;
	fpc_adv_t              adv;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic                  inside_s4;
	logic [NUM_PLANES-1:0] failed_s4;

	fpc_plane_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.plane    (plane)
	);

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
		fpc_plane_eval #(
			.COORD_WIDTH  (COORD_WIDTH),
			.NORMAL_WIDTH (NORMAL_WIDTH)
		) u_eval (
			.clk     (clk),
			.adv     (adv),
			.px      (pt.px),
			.py      (pt.py),
			.pz      (pt.pz),
			.plane   (plane[i]),
			.fail_s3 (fail_s3[i])
		);
	end

	// a stage loads when it is empty or its content moves on
	assign rdy_s4 = !v_s4 || res.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign adv.s1 = rdy_s1;
	assign adv.s2 = rdy_s2;
	assign adv.s3 = rdy_s3;

	assign pt.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pt.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			inside_s4 <= (fail_s3 == '0);
			failed_s4 <= fail_s3;
		end
	end

	assign res.valid         = v_s4;
	assign res.inside_res    = inside_s4;
	assign res.failed_planes = failed_s4;

endmodule
